/* sv/stereo_biquad_cascade_eq_unit_assert.svh */
// Assertion macros used by the checker file.
// Each macro takes a label, an antecedent and a consequent, and samples on
// clk with the check held off while rst_n is low.
`ifndef STEREO_BIQUAD_CASCADE_EQ_UNIT_ASSERT_SVH
`define STEREO_BIQUAD_CASCADE_EQ_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BQEQ_CHK_SAME(lbl, ant, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) \
    else $error("bqeq port check failed");

// Consequent must hold in the cycle after the antecedent.
`define BQEQ_CHK_NEXT(lbl, ant, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) \
    else $error("bqeq port check failed");

`endif

/* sv/bqeq_pkg.sv */
`default_nettype none

package bqeq_pkg;

  // Fixed formats
  localparam int SAMPLE_BITS = 24;
  localparam int COEFF_BITS  = 18;
  localparam int COEFF_FRAC  = COEFF_BITS - 4;
  localparam int DELAY_BITS  = 40;
  localparam int BANDS       = 4;
  localparam int MAX_BANDS   = 4;
  localparam int BAND_W      = $clog2(MAX_BANDS);

  // Arithmetic widths
  localparam int PROD_W = COEFF_BITS + DELAY_BITS;
  localparam int ACC_W  = PROD_W + 1;
  localparam int RND_W  = ACC_W - COEFF_FRAC;
  localparam int FIN_W  = RND_W + 1;

  // Delay store: {band, channel, k}
  localparam int DLY_ADDR_W = BAND_W + 2;
  localparam int DLY_DEPTH  = 1 << DLY_ADDR_W;

  // Configuration registers
  localparam int FF_W       = 3 * COEFF_BITS;
  localparam int FB_W       = 2 * COEFF_BITS;
  localparam int CFG_DATA_W = 64;
  localparam int REG_IDX_W  = BAND_W + 1;
  localparam int CFG_ADDR_W = REG_IDX_W + 3;
  localparam logic REG_KIND_FF = 1'b0;
  localparam logic REG_KIND_FB = 1'b1;
  localparam logic [FF_W-1:0] FF_RESET = FF_W'(1) << COEFF_FRAC;
  localparam logic [FB_W-1:0] FB_RESET = '0;

  // Program counter
  localparam int STEP_W = 3;

  // Saturation limits
  localparam logic signed [DELAY_BITS-1:0] DLY_HI = {1'b0, {(DELAY_BITS-1){1'b1}}};
  localparam logic signed [DELAY_BITS-1:0] DLY_LO = {1'b1, {(DELAY_BITS-1){1'b0}}};
  localparam logic signed [FIN_W-1:0] DLY_HI_EXT = FIN_W'(DLY_HI);
  localparam logic signed [FIN_W-1:0] DLY_LO_EXT = FIN_W'(DLY_LO);
  localparam logic signed [SAMPLE_BITS-1:0] SMP_HI = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] SMP_LO = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam logic signed [DELAY_BITS-1:0] SMP_HI_EXT = DELAY_BITS'(SMP_HI);
  localparam logic signed [DELAY_BITS-1:0] SMP_LO_EXT = DELAY_BITS'(SMP_LO);

  // Control word fields
  typedef enum logic [2:0] {
    C_B0 = 3'd0,
    C_B1 = 3'd1,
    C_B2 = 3'd2,
    C_A1 = 3'd3,
    C_A2 = 3'd4
  } coef_sel_t;

  typedef enum logic {
    OPND_X = 1'b0,
    OPND_Y = 1'b1
  } opnd_sel_t;

  typedef enum logic [1:0] {
    ACC_NONE = 2'd0,
    ACC_LOAD = 2'd1,
    ACC_SUB  = 2'd2
  } acc_op_t;

  typedef enum logic [1:0] {
    FIN_NONE = 2'd0,
    FIN_Y    = 2'd1,
    FIN_Z1   = 2'd2,
    FIN_Z2   = 2'd3
  } fin_op_t;

  typedef enum logic {
    SEQ_NEXT = 1'b0,
    SEQ_END  = 1'b1
  } seq_op_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_RUN  = 1'b1
  } seq_state_t;

  typedef struct packed {
    logic      mul_en;
    coef_sel_t coef_sel;
    opnd_sel_t opnd_sel;
    acc_op_t   acc_op;
    fin_op_t   fin_op;
    logic      rd_en;
    logic      rd_k;
    seq_op_t   seq_op;
  } ucode_t;

  // Sequencer to datapath
  typedef struct packed {
    logic              load;
    logic              step_en;
    ucode_t            word;
    logic [BAND_W-1:0] band;
    logic              ch;
    logic              last_band;
    logic              done;
  } dp_cmd_t;

  // Section program: y = b0*x + z1, z1 = b1*x - a1*y + z2, z2 = b2*x - a2*y
  function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] pc);
    ucode_t w;
    w = '{mul_en: 1'b0, coef_sel: C_B0, opnd_sel: OPND_X, acc_op: ACC_NONE,
          fin_op: FIN_NONE, rd_en: 1'b0, rd_k: 1'b0, seq_op: SEQ_NEXT};
    unique case (pc)
      3'd0: begin
        w.mul_en = 1'b1; w.coef_sel = C_B0; w.opnd_sel = OPND_X;
        w.rd_en = 1'b1; w.rd_k = 1'b0;
      end
      3'd1: begin
        w.acc_op = ACC_LOAD;
      end
      3'd2: begin
        w.fin_op = FIN_Y;
        w.mul_en = 1'b1; w.coef_sel = C_B1; w.opnd_sel = OPND_X;
        w.rd_en = 1'b1; w.rd_k = 1'b1;
      end
      3'd3: begin
        w.acc_op = ACC_LOAD;
        w.mul_en = 1'b1; w.coef_sel = C_A1; w.opnd_sel = OPND_Y;
      end
      3'd4: begin
        w.acc_op = ACC_SUB;
        w.mul_en = 1'b1; w.coef_sel = C_B2; w.opnd_sel = OPND_X;
      end
      3'd5: begin
        w.fin_op = FIN_Z1;
        w.acc_op = ACC_LOAD;
        w.mul_en = 1'b1; w.coef_sel = C_A2; w.opnd_sel = OPND_Y;
      end
      3'd6: begin
        w.acc_op = ACC_SUB;
      end
      3'd7: begin
        w.fin_op = FIN_Z2;
        w.seq_op = SEQ_END;
      end
      default: begin
        w.seq_op = SEQ_END;
      end
    endcase
    return w;
  endfunction

  function automatic logic signed [DELAY_BITS-1:0] sat_delay(
    input logic signed [FIN_W-1:0] v
  );
    logic signed [DELAY_BITS-1:0] r;
    if (v > DLY_HI_EXT) r = DLY_HI;
    else if (v < DLY_LO_EXT) r = DLY_LO;
    else r = v[DELAY_BITS-1:0];
    return r;
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(
    input logic signed [DELAY_BITS-1:0] v
  );
    logic signed [SAMPLE_BITS-1:0] r;
    if (v > SMP_HI_EXT) r = SMP_HI;
    else if (v < SMP_LO_EXT) r = SMP_LO;
    else r = v[SAMPLE_BITS-1:0];
    return r;
  endfunction

endpackage

`default_nettype wire

/* sv/bqeq_ifs.sv */
`default_nettype none

// Stereo sample word in
interface bqeq_in_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [bqeq_pkg::SAMPLE_BITS-1:0] left_in;
  logic signed [bqeq_pkg::SAMPLE_BITS-1:0] right_in;
  logic                                   clear_delays;

  modport source (output valid, output left_in, output right_in, output clear_delays,
                  input ready);
  modport sink   (input valid, input left_in, input right_in, input clear_delays,
                  output ready);
endinterface

// Filtered stereo word out
interface bqeq_out_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [bqeq_pkg::SAMPLE_BITS-1:0] left_out;
  logic signed [bqeq_pkg::SAMPLE_BITS-1:0] right_out;

  modport source (output valid, output left_out, output right_out, input ready);
  modport sink   (input valid, input left_out, input right_out, output ready);
endinterface

`default_nettype wire

/* sv/bqeq_cfg.sv */
`default_nettype none

module bqeq_cfg (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic                                   psel,
  input  wire logic                                   penable,
  input  wire logic                                   pwrite,
  input  wire logic [bqeq_pkg::CFG_ADDR_W-1:0]        paddr,
  input  wire logic [bqeq_pkg::CFG_DATA_W-1:0]        pwdata,
  output logic      [bqeq_pkg::CFG_DATA_W-1:0]        prdata,
  output logic                                        pready,
  input  wire logic [bqeq_pkg::BAND_W-1:0]            band,
  input  wire bqeq_pkg::coef_sel_t                    coef_sel,
  output logic signed [bqeq_pkg::COEFF_BITS-1:0]      coef
);

  logic [bqeq_pkg::FF_W-1:0]      ff_r [bqeq_pkg::MAX_BANDS];
  logic [bqeq_pkg::FB_W-1:0]      fb_r [bqeq_pkg::MAX_BANDS];
  logic [bqeq_pkg::REG_IDX_W-1:0] reg_idx;
  logic [bqeq_pkg::BAND_W-1:0]    reg_band;
  logic                           reg_kind;
  logic                           wr_en;

  assign reg_idx  = paddr[bqeq_pkg::CFG_ADDR_W-1:3];
  assign reg_band = reg_idx[bqeq_pkg::REG_IDX_W-1:1];
  assign reg_kind = reg_idx[0];
  assign wr_en    = psel && penable && pwrite;
  assign pready   = 1'b1;

  // Write coefficient registers, reset to unity bypass
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int b = 0; b < bqeq_pkg::MAX_BANDS; b++) begin
        ff_r[b] <= bqeq_pkg::FF_RESET;
        fb_r[b] <= bqeq_pkg::FB_RESET;
      end
    end else if (wr_en) begin
      if (reg_kind == bqeq_pkg::REG_KIND_FF) begin
        ff_r[reg_band] <= pwdata[bqeq_pkg::FF_W-1:0];
      end else begin
        fb_r[reg_band] <= pwdata[bqeq_pkg::FB_W-1:0];
      end
    end
  end

  // Read back
  always_comb begin
    if (reg_kind == bqeq_pkg::REG_KIND_FF) begin
      prdata = bqeq_pkg::CFG_DATA_W'(ff_r[reg_band]);
    end else begin
      prdata = bqeq_pkg::CFG_DATA_W'(fb_r[reg_band]);
    end
  end

  // Pick the coefficient the current step multiplies by
  always_comb begin
    unique case (coef_sel)
      bqeq_pkg::C_B0: coef = signed'(ff_r[band][0*bqeq_pkg::COEFF_BITS +: bqeq_pkg::COEFF_BITS]);
      bqeq_pkg::C_B1: coef = signed'(ff_r[band][1*bqeq_pkg::COEFF_BITS +: bqeq_pkg::COEFF_BITS]);
      bqeq_pkg::C_B2: coef = signed'(ff_r[band][2*bqeq_pkg::COEFF_BITS +: bqeq_pkg::COEFF_BITS]);
      bqeq_pkg::C_A1: coef = signed'(fb_r[band][0*bqeq_pkg::COEFF_BITS +: bqeq_pkg::COEFF_BITS]);
      bqeq_pkg::C_A2: coef = signed'(fb_r[band][1*bqeq_pkg::COEFF_BITS +: bqeq_pkg::COEFF_BITS]);
      default:        coef = '0;
    endcase
  end

endmodule

`default_nettype wire

/* sv/bqeq_seq.sv */
`default_nettype none

module bqeq_seq (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output bqeq_pkg::dp_cmd_t      cmd
);

  bqeq_pkg::seq_state_t              state_r, state_nxt;
  logic [bqeq_pkg::STEP_W-1:0]       pc_r, pc_nxt;
  logic [bqeq_pkg::BAND_W-1:0]       band_r, band_nxt;
  logic                              ch_r, ch_nxt;
  logic                              out_valid_r, out_valid_nxt;
  bqeq_pkg::ucode_t                  word;
  logic                              running;
  logic                              sec_end;
  logic                              last_band;
  logic                              done_step;
  logic                              stall;
  logic                              step_en;
  logic                              load;

  // Fetch the control word for this step
  assign word      = bqeq_pkg::ucode_rom(pc_r);
  assign running   = (state_r == bqeq_pkg::S_RUN);
  assign last_band = (band_r == bqeq_pkg::BAND_W'(bqeq_pkg::BANDS - 1));
  assign sec_end   = running && (word.seq_op == bqeq_pkg::SEQ_END);
  assign done_step = sec_end && last_band && ch_r;
  // Hold the final step while the previous result still waits
  assign stall     = done_step && out_valid_r && !out_ready;
  assign step_en   = running && !stall;
  assign in_ready  = !running;
  assign load      = in_valid && in_ready;
  assign out_valid = out_valid_r;

  assign cmd = '{load: load, step_en: step_en, word: word, band: band_r, ch: ch_r,
                 last_band: last_band, done: done_step};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bqeq_pkg::S_IDLE;
      pc_r        <= '0;
      band_r      <= '0;
      ch_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pc_r        <= pc_nxt;
      band_r      <= band_nxt;
      ch_r        <= ch_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Step counter, band and channel loops
  always_comb begin
    state_nxt = state_r;
    pc_nxt    = pc_r;
    band_nxt  = band_r;
    ch_nxt    = ch_r;
    unique case (state_r)
      bqeq_pkg::S_IDLE: begin
        if (load) begin
          state_nxt = bqeq_pkg::S_RUN;
          pc_nxt    = '0;
          band_nxt  = '0;
          ch_nxt    = 1'b0;
        end
      end
      bqeq_pkg::S_RUN: begin
        if (step_en) begin
          if (word.seq_op == bqeq_pkg::SEQ_END) begin
            pc_nxt = '0;
            if (!last_band) begin
              band_nxt = band_r + bqeq_pkg::BAND_W'(1);
            end else if (!ch_r) begin
              band_nxt = '0;
              ch_nxt   = 1'b1;
            end else begin
              state_nxt = bqeq_pkg::S_IDLE;
            end
          end else begin
            pc_nxt = pc_r + bqeq_pkg::STEP_W'(1);
          end
        end
      end
      default: begin
        state_nxt = bqeq_pkg::S_IDLE;
      end
    endcase
  end

  // Result word valid: set on the last step, drop once taken
  always_comb begin
    if (step_en && done_step) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

endmodule

`default_nettype wire

/* sv/bqeq_dp.sv */
`default_nettype none

module bqeq_dp (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire bqeq_pkg::dp_cmd_t                    cmd,
  input  wire logic signed [bqeq_pkg::SAMPLE_BITS-1:0] left_in,
  input  wire logic signed [bqeq_pkg::SAMPLE_BITS-1:0] right_in,
  input  wire logic                                 clear_delays,
  input  wire logic signed [bqeq_pkg::COEFF_BITS-1:0]  coef,
  output logic signed [bqeq_pkg::SAMPLE_BITS-1:0]   left_out,
  output logic signed [bqeq_pkg::SAMPLE_BITS-1:0]   right_out
);

  localparam logic signed [bqeq_pkg::ACC_W-1:0] ROUND_HALF =
    bqeq_pkg::ACC_W'(1) << (bqeq_pkg::COEFF_FRAC - 1);

  // Delay store with per-entry valid bits; an invalid entry reads as zero
  logic [bqeq_pkg::DELAY_BITS-1:0] dly_mem [bqeq_pkg::DLY_DEPTH];
  logic [bqeq_pkg::DLY_DEPTH-1:0]  dly_vld_r, dly_vld_nxt;

  logic signed [bqeq_pkg::DELAY_BITS-1:0]  x_r, x_nxt;
  logic signed [bqeq_pkg::DELAY_BITS-1:0]  y_r, y_nxt;
  logic signed [bqeq_pkg::DELAY_BITS-1:0]  rd_r;
  logic signed [bqeq_pkg::PROD_W-1:0]      prod_r, prod_nxt;
  logic signed [bqeq_pkg::ACC_W-1:0]       acc_r, acc_nxt;
  logic signed [bqeq_pkg::SAMPLE_BITS-1:0] right_hold_r, right_hold_nxt;
  logic signed [bqeq_pkg::SAMPLE_BITS-1:0] left_res_r, left_res_nxt;
  logic signed [bqeq_pkg::SAMPLE_BITS-1:0] out_left_r, out_left_nxt;
  logic signed [bqeq_pkg::SAMPLE_BITS-1:0] out_right_r, out_right_nxt;

  logic signed [bqeq_pkg::DELAY_BITS-1:0]  opnd;
  logic signed [bqeq_pkg::ACC_W-1:0]       rnd_sum;
  logic signed [bqeq_pkg::RND_W-1:0]       rnd;
  logic signed [bqeq_pkg::DELAY_BITS-1:0]  addend;
  logic signed [bqeq_pkg::FIN_W-1:0]       fin_sum;
  logic signed [bqeq_pkg::DELAY_BITS-1:0]  fin_val;
  logic [bqeq_pkg::DLY_ADDR_W-1:0]         rd_addr;
  logic [bqeq_pkg::DLY_ADDR_W-1:0]         wr_addr;
  logic                                    wr_en;
  logic                                    sec_end;

  // Multiply operand and product
  assign opnd     = (cmd.word.opnd_sel == bqeq_pkg::OPND_Y) ? y_r : x_r;
  assign prod_nxt = (cmd.step_en && cmd.word.mul_en)
                  ? bqeq_pkg::PROD_W'(coef) * bqeq_pkg::PROD_W'(opnd) : prod_r;

  // Accumulate products of one equation exactly
  always_comb begin
    acc_nxt = acc_r;
    if (cmd.step_en) begin
      unique case (cmd.word.acc_op)
        bqeq_pkg::ACC_NONE: acc_nxt = acc_r;
        bqeq_pkg::ACC_LOAD: acc_nxt = bqeq_pkg::ACC_W'(prod_r);
        bqeq_pkg::ACC_SUB:  acc_nxt = acc_r - bqeq_pkg::ACC_W'(prod_r);
        default:            acc_nxt = acc_r;
      endcase
    end
  end

  // Round to signal precision, add the old delay (none for z2), saturate
  assign rnd_sum = acc_r + ROUND_HALF;
  assign rnd     = signed'(rnd_sum[bqeq_pkg::ACC_W-1:bqeq_pkg::COEFF_FRAC]);
  assign addend  = (cmd.word.fin_op == bqeq_pkg::FIN_Z2) ? '0 : rd_r;
  assign fin_sum = bqeq_pkg::FIN_W'(rnd) + bqeq_pkg::FIN_W'(addend);
  assign fin_val = bqeq_pkg::sat_delay(fin_sum);

  assign rd_addr = {cmd.band, cmd.ch, cmd.word.rd_k};
  assign wr_addr = {cmd.band, cmd.ch, (cmd.word.fin_op == bqeq_pkg::FIN_Z2)};
  assign wr_en   = cmd.step_en &&
                   ((cmd.word.fin_op == bqeq_pkg::FIN_Z1) ||
                    (cmd.word.fin_op == bqeq_pkg::FIN_Z2));
  assign sec_end = cmd.step_en && (cmd.word.seq_op == bqeq_pkg::SEQ_END);

  assign y_nxt = (cmd.step_en && (cmd.word.fin_op == bqeq_pkg::FIN_Y)) ? fin_val : y_r;

  // Valid bits: drop all on a clearing word, set on each delay write
  always_comb begin
    dly_vld_nxt = dly_vld_r;
    if (cmd.load && clear_delays) begin
      dly_vld_nxt = '0;
    end else if (wr_en) begin
      dly_vld_nxt[wr_addr] = 1'b1;
    end
  end

  // Section input, channel hand-over and result capture
  always_comb begin
    x_nxt          = x_r;
    right_hold_nxt = right_hold_r;
    left_res_nxt   = left_res_r;
    out_left_nxt   = out_left_r;
    out_right_nxt  = out_right_r;
    if (cmd.load) begin
      x_nxt          = bqeq_pkg::DELAY_BITS'(left_in);
      right_hold_nxt = right_in;
    end else if (sec_end) begin
      if (!cmd.last_band) begin
        x_nxt = y_r;
      end else if (!cmd.ch) begin
        left_res_nxt = bqeq_pkg::sat_sample(y_r);
        x_nxt        = bqeq_pkg::DELAY_BITS'(right_hold_r);
      end else begin
        out_left_nxt  = left_res_r;
        out_right_nxt = bqeq_pkg::sat_sample(y_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dly_vld_r <= '0;
    end else begin
      dly_vld_r <= dly_vld_nxt;
    end
  end

  // Delay store write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      dly_mem[wr_addr] <= fin_val;
    end
    if (cmd.step_en && cmd.word.rd_en) begin
      rd_r <= dly_vld_r[rd_addr] ? signed'(dly_mem[rd_addr]) : '0;
    end
  end

  always_ff @(posedge clk) begin
    x_r          <= x_nxt;
    y_r          <= y_nxt;
    prod_r       <= prod_nxt;
    acc_r        <= acc_nxt;
    right_hold_r <= right_hold_nxt;
    left_res_r   <= left_res_nxt;
    out_left_r   <= out_left_nxt;
    out_right_r  <= out_right_nxt;
  end

  assign left_out  = out_left_r;
  assign right_out = out_right_r;

endmodule

`default_nettype wire

/* sv/stereo_biquad_cascade_eq_unit.sv */
`default_nettype none

// Stereo four-band equalizer: each word is a left/right Q1.23 pair that runs
// through four transposed direct form II biquads per channel, all bands sharing
// one 18x40 multiplier under an eight-step section program. A word runs the
// eight steps for each band of each channel in turn from acceptance to a valid
// result, and a new word is accepted the cycle after the previous one finishes,
// so words do not overlap; the single shared multiplier and its five products
// per section set the pace. The finished result sits in an output register, so
// the next word is taken while it waits; only the final step of the following
// word holds if the result is still not taken by then.
// Coefficients (signed Q4.14) sit at byte address 8*i: even registers hold
// b0,b1,b2 and odd ones a1,a2 of band i/2, each field lowest first. Reset sets
// every band to unity bypass and zeroes all delays; a word with clear_delays
// set zeroes all delays before it is filtered. No clearing pass is needed.
module stereo_biquad_cascade_eq_unit (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  bqeq_in_if.sink                                    in_ch,
  bqeq_out_if.source                                 out_ch,
  input  wire logic                                  cfg_psel,
  input  wire logic                                  cfg_penable,
  input  wire logic                                  cfg_pwrite,
  input  wire logic [bqeq_pkg::CFG_ADDR_W-1:0]       cfg_paddr,
  input  wire logic [bqeq_pkg::CFG_DATA_W-1:0]       cfg_pwdata,
  output logic      [bqeq_pkg::CFG_DATA_W-1:0]       cfg_prdata,
  output logic                                       cfg_pready
);

  bqeq_pkg::dp_cmd_t                     cmd;
  logic signed [bqeq_pkg::COEFF_BITS-1:0] coef;
  logic                                  in_ready;
  logic                                  out_valid;
  logic signed [bqeq_pkg::SAMPLE_BITS-1:0] left_out;
  logic signed [bqeq_pkg::SAMPLE_BITS-1:0] right_out;

  bqeq_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .psel     (cfg_psel),
    .penable  (cfg_penable),
    .pwrite   (cfg_pwrite),
    .paddr    (cfg_paddr),
    .pwdata   (cfg_pwdata),
    .prdata   (cfg_prdata),
    .pready   (cfg_pready),
    .band     (cmd.band),
    .coef_sel (cmd.word.coef_sel),
    .coef     (coef)
  );

  bqeq_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd)
  );

  bqeq_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .left_in      (in_ch.left_in),
    .right_in     (in_ch.right_in),
    .clear_delays (in_ch.clear_delays),
    .coef         (coef),
    .left_out     (left_out),
    .right_out    (right_out)
  );

  assign in_ch.ready      = in_ready;
  assign out_ch.valid     = out_valid;
  assign out_ch.left_out  = left_out;
  assign out_ch.right_out = right_out;

endmodule

`default_nettype wire

/* sv/bqeq_chk.sv */
`default_nettype none

`include "stereo_biquad_cascade_eq_unit_assert.svh"

module bqeq_chk (
  input wire logic                                   clk,
  input wire logic                                   rst_n,
  input wire logic                                   in_valid,
  input wire logic                                   in_ready,
  input wire logic                                   out_valid,
  input wire logic                                   out_ready,
  input wire logic signed [bqeq_pkg::SAMPLE_BITS-1:0] out_left,
  input wire logic signed [bqeq_pkg::SAMPLE_BITS-1:0] out_right
);

  // A result word stays offered until taken
  `BQEQ_CHK_NEXT(a_out_hold, out_valid && !out_ready, out_valid)

  // A stalled result word keeps its samples
  `BQEQ_CHK_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_left) && $stable(out_right))

  // An accepted word keeps the block busy for the next cycle
  `BQEQ_CHK_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)

  // A new result only appears at the end of a busy stretch
  `BQEQ_CHK_SAME(a_result_after_busy, $rose(out_valid), !$past(in_ready))

endmodule

bind stereo_biquad_cascade_eq_unit bqeq_chk u_bqeq_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_left  (out_ch.left_out),
  .out_right (out_ch.right_out)
);

`default_nettype wire
